FILE: sv/atws_pkg.sv
// ----------------------------------------------------------------------------
// Alarm table package
// Shared widths, result codes, cell interface structs and the time helper
// used by the alarm cells and the top level.
// ----------------------------------------------------------------------------
package atws_pkg;

	// Table size and derived widths.
	localparam int NUM_ALARMS  = 16;
	localparam int CNT_W       = $clog2(NUM_ALARMS + 1);
	localparam int MASK_W      = 16;
	localparam int MAX_RESULTS = 16;
	localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

	// Field widths.
	localparam int HOUR_W = 5;
	localparam int MIN_W  = 6;
	localparam int SLOT_W = 4;
	localparam int EV_W   = 2;

	// Time constants.
	localparam logic [3:0]        SNOOZE_STEP  = 4'd10;
	localparam logic [MIN_W-1:0]  MIN_PER_HOUR = 6'd60;
	localparam logic [HOUR_W-1:0] HR_PER_DAY   = 5'd24;

	// Result codes.
	localparam logic [EV_W-1:0] EV_TRIGGERED = 2'd0;
	localparam logic [EV_W-1:0] EV_ADDED     = 2'd1;
	localparam logic [EV_W-1:0] EV_REJ_FULL  = 2'd2;
	localparam logic [EV_W-1:0] EV_REJ_TIME  = 2'd3;

	// Input kind codes.
	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Time of day.
	typedef struct packed {
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
	} tod_t;

	// Control from the walker to every cell.
	typedef struct packed {
		logic shift;   // move the walk token one cell on
		logic clear;   // drop the walk token
		logic commit;  // apply snooze or dismiss in the token cell
	} cell_ctl_t;

	// What a cell reports while it holds the token.
	typedef struct packed {
		logic              fire;
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic              snz;
	} cell_fire_t;

	// One result word before it goes out.
	typedef struct packed {
		logic [EV_W-1:0]   event_res;
		logic [SLOT_W-1:0] slot;
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic              snz;
	} res_t;

	// Add a few minutes (less than an hour) to a valid time, wrapping at the
	// hour and at midnight.
	function automatic tod_t tod_add(input tod_t t, input logic [3:0] inc);
		logic [MIN_W:0] sum;
		tod_t           r;
		sum = {1'b0, t.minute} + {3'b000, inc};
		r   = t;
		if (sum >= {1'b0, MIN_PER_HOUR}) begin
			r.minute = MIN_W'(sum - {1'b0, MIN_PER_HOUR});
			if (t.hour == HR_PER_DAY - 5'd1) begin
				r.hour = '0;
			end else begin
				r.hour = t.hour + 5'd1;
			end
		end else begin
			r.minute = MIN_W'(sum);
		end
		return r;
	endfunction

endpackage

FILE: sv/atws_cell.sv
// ----------------------------------------------------------------------------
// Alarm cell
// Holds one table slot and one stage of the walk token chain. While it holds
// the token it compares its alarm with the current time and, on commit,
// snoozes or dismisses a snoozeable alarm that fires.
// ----------------------------------------------------------------------------
module atws_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  atws_pkg::cell_ctl_t           ctl,
	input  logic                          tok_in,
	output logic                          tok_q,
	input  logic                          wr,
	input  atws_pkg::tod_t                wr_time,
	input  logic                          wr_snz,
	input  atws_pkg::tod_t                now,
	input  logic                          snooze,
	output atws_pkg::cell_fire_t          fire
);

	atws_pkg::tod_t alarm_q;
	logic           snz_q;
	logic           en_q;

	// The token moves along the chain one cell per step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (ctl.clear) begin
			tok_q <= 1'b0;
		end else if (ctl.shift) begin
			tok_q <= tok_in;
		end
	end

	// Report only while this cell holds the token; otherwise drive zeros so
	// the outputs of all cells can be merged by OR.
	always_comb begin
		fire.fire   = tok_q && en_q && (alarm_q == now);
		fire.hour   = tok_q ? alarm_q.hour : '0;
		fire.minute = tok_q ? alarm_q.minute : '0;
		fire.snz    = tok_q ? snz_q : 1'b0;
	end

	// Slot contents: written by an add, changed by a committed firing.
	always_ff @(posedge clk) begin
		if (wr) begin
			alarm_q <= wr_time;
			snz_q   <= wr_snz;
			en_q    <= 1'b1;
		end else if (ctl.commit && fire.fire && snz_q) begin
			if (snooze) begin
				alarm_q <= atws_pkg::tod_add(alarm_q, atws_pkg::SNOOZE_STEP);
			end else begin
				en_q <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/alarm_table_with_snooze_top.sv
// ----------------------------------------------------------------------------
// Alarm table with snooze
// Keeps the time of day and a table of alarms in a chain of cells. Add words
// store alarms; tick words walk the table, report firing alarms, snooze or
// dismiss the snoozeable ones and advance the clock by one minute.
//
//   Channel  Dir  Signals                      Contents
//   s_*      in   tvalid tready tdata tuser    add or tick word
//   m_*      out  tvalid tready tdata tuser    result word, tlast on the final
//                 tlast                        result of each input word
//
// An add is accepted, then its result is handed off. A tick is accepted, the
// token walks the cell chain one stored alarm per step, and the final result,
// if any, is handed off. A stalled output holds the walk only when a second
// result is ready behind the one already waiting. Reset clears the clock and
// the alarm count; slot contents are meaningful only once written.
// ----------------------------------------------------------------------------
module alarm_table_with_snooze_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // alarm_hour, alarm_minute, is_snoozeable, snooze_mask, pad
	input  logic        s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // slot, fire_hour, fire_minute, was_snoozeable
	output logic [1:0]  m_tuser,  // event_res
	output logic        m_tlast
);

	localparam int N = atws_pkg::NUM_ALARMS;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]                      state_q;
	atws_pkg::tod_t                  now_q;
	logic [atws_pkg::CNT_W-1:0]      count_q;
	logic [atws_pkg::CNT_W-1:0]      idx_q;
	logic [atws_pkg::CNT_W-1:0]      idx_next;
	logic [atws_pkg::RCNT_W-1:0]     rcnt_q;
	logic [atws_pkg::MASK_W-1:0]     mask_q;
	atws_pkg::res_t                  hold_q;
	logic                            hold_v_q;
	atws_pkg::res_t                  out_q;
	logic                            out_last_q;
	logic                            out_v_q;

	// Input word fields.
	atws_pkg::tod_t                  in_time;
	logic                            in_snz;
	logic [atws_pkg::MASK_W-1:0]     in_mask;
	logic                            in_take;
	logic                            add_take;
	logic                            tick_take;
	logic                            add_full;
	logic                            add_bad;
	logic                            add_ok;

	// Walk control.
	logic                            can_push;
	logic                            fire_take;
	logic                            need_push;
	logic                            walk_step;
	logic                            walk_end;
	logic                            start;
	atws_pkg::cell_ctl_t             ctl;
	logic [N-1:0]                    tok;
	atws_pkg::cell_fire_t            cell_out [N];
	atws_pkg::cell_fire_t            bus;
	atws_pkg::res_t                  trig_res;

	assign in_time.hour   = s_tdata[4:0];
	assign in_time.minute = s_tdata[10:5];
	assign in_snz         = s_tdata[11];
	assign in_mask        = s_tdata[27:12];

	assign s_tready  = (state_q == ST_IDLE);
	assign in_take   = s_tvalid && s_tready;
	assign add_take  = in_take && (s_tuser == atws_pkg::KIND_ADD);
	assign tick_take = in_take && (s_tuser == atws_pkg::KIND_TICK);

	// Add checks: a full table wins over a bad time.
	assign add_full = (count_q >= atws_pkg::CNT_W'(N));
	assign add_bad  = (in_time.hour >= atws_pkg::HR_PER_DAY) ||
	                  (in_time.minute >= atws_pkg::MIN_PER_HOUR);
	assign add_ok   = add_take && !add_full && !add_bad;

	// Walk stepping: stall only when a second result needs the output register.
	assign can_push  = !out_v_q || m_tready;
	assign fire_take = bus.fire && (rcnt_q < atws_pkg::RCNT_W'(atws_pkg::MAX_RESULTS));
	assign need_push = fire_take && hold_v_q;
	assign walk_step = (state_q == ST_WALK) && (!need_push || can_push);
	assign idx_next  = idx_q + 1'b1;
	assign walk_end  = walk_step && (idx_next == count_q);
	assign start     = tick_take && (count_q != '0);

	assign ctl.shift  = start || (walk_step && !walk_end);
	assign ctl.clear  = walk_end;
	assign ctl.commit = walk_step;

	// Chain of alarm cells.
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic tok_in;
		logic snooze;
		if (i == 0) begin : g_head
			assign tok_in = start;
		end else begin : g_link
			assign tok_in = tok[i-1];
		end
		if (i < atws_pkg::MASK_W) begin : g_mask
			assign snooze = mask_q[i];
		end else begin : g_nomask
			assign snooze = 1'b0;
		end
		atws_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.tok_in  (tok_in),
			.tok_q   (tok[i]),
			.wr      (add_ok && (count_q == atws_pkg::CNT_W'(i))),
			.wr_time (in_time),
			.wr_snz  (in_snz),
			.now     (now_q),
			.snooze  (snooze),
			.fire    (cell_out[i])
		);
	end

	// Only the token cell can report, so the cell outputs merge by OR.
	always_comb begin
		bus = '0;
		for (int i = 0; i < N; i++) begin
			bus = atws_pkg::cell_fire_t'(bus | cell_out[i]);
		end
	end

	always_comb begin
		trig_res.event_res = atws_pkg::EV_TRIGGERED;
		trig_res.slot      = atws_pkg::SLOT_W'(idx_q);
		trig_res.hour      = bus.hour;
		trig_res.minute    = bus.minute;
		trig_res.snz       = bus.snz;
	end

	// Sequencer, clock of day, alarm count and the pending result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			now_q    <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			rcnt_q   <= '0;
			hold_v_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (add_take) begin
						hold_v_q <= 1'b1;
						state_q  <= ST_FLUSH;
						if (add_ok) begin
							count_q <= count_q + 1'b1;
						end
					end else if (tick_take) begin
						idx_q  <= '0;
						rcnt_q <= '0;
						if (count_q == '0) begin
							now_q   <= atws_pkg::tod_add(now_q, 4'd1);
							state_q <= ST_FLUSH;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (walk_step) begin
						if (fire_take) begin
							hold_v_q <= 1'b1;
							rcnt_q   <= rcnt_q + 1'b1;
						end
						if (walk_end) begin
							now_q   <= atws_pkg::tod_add(now_q, 4'd1);
							state_q <= ST_FLUSH;
						end else begin
							idx_q <= idx_next;
						end
					end
				end
				ST_FLUSH: begin
					if (!hold_v_q) begin
						state_q <= ST_IDLE;
					end else if (can_push) begin
						hold_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Pending result payload and the captured snooze mask.
	always_ff @(posedge clk) begin
		if (tick_take) begin
			mask_q <= in_mask;
		end
		if (add_take) begin
			if (add_full) begin
				hold_q <= '{event_res: atws_pkg::EV_REJ_FULL, default: '0};
			end else if (add_bad) begin
				hold_q <= '{event_res: atws_pkg::EV_REJ_TIME, default: '0};
			end else begin
				hold_q.event_res <= atws_pkg::EV_ADDED;
				hold_q.slot      <= atws_pkg::SLOT_W'(count_q);
				hold_q.hour      <= in_time.hour;
				hold_q.minute    <= in_time.minute;
				hold_q.snz       <= in_snz;
			end
		end else if (walk_step && fire_take) begin
			hold_q <= trig_res;
		end
	end

	// Output register: a pending result leaves when a later one arrives
	// (not last) or when the flush finds it (last).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if ((walk_step && need_push) ||
		             ((state_q == ST_FLUSH) && hold_v_q && can_push)) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (walk_step && need_push) begin
			out_q      <= hold_q;
			out_last_q <= 1'b0;
		end else if ((state_q == ST_FLUSH) && hold_v_q && can_push) begin
			out_q      <= hold_q;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.event_res;
	assign m_tdata  = {out_q.snz, out_q.minute, out_q.hour, out_q.slot};
	assign m_tlast  = out_last_q;

endmodule
